// ===== rtl/wra_pkg.sv =====
// Shared types and constants for the windowed running average block.
// Holds the request and response transaction structs and the op codes.
// No dependencies; imported by the core and the checker.
`default_nettype none

package wra_pkg;

    // Fixed field widths of the two channels
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned FILL_W      = 7;
    localparam int unsigned PTR_FIELD_W = 6;
    localparam int unsigned SUM_FIELD_W = 22;
    localparam int unsigned MEAN_W      = 24;

    // Fraction bits of the mean
    localparam int unsigned FRAC_W = 8;

    // Widest sample the window may be built for
    localparam int unsigned SAMPLE_W_MAX = 32;

    // Op codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                op;
        logic [SAMPLE_W-1:0] sample;
    } wra_req_t;

    typedef struct packed {
        logic [FILL_W-1:0]      fill_count;
        logic [PTR_FIELD_W-1:0] write_pointer;
        logic [SUM_FIELD_W-1:0] window_sum;
        logic [MEAN_W-1:0]      mean_q8;
    } wra_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/wra_div.sv =====
// Bit-serial restoring divider used for the window mean.
// One quotient bit per cycle; start loads the operands, done pulses at the end.
// Depends on nothing outside this file.
`default_nettype none

module wra_div #(
    parameter int unsigned DIVIDEND_W = 31,
    parameter int unsigned DIVISOR_W  = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);
    localparam int unsigned REM_W  = DIVISOR_W + 1;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  done_reg, done_next;

    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] diff;
    logic             take;

    // Shift in the next dividend bit and trial-subtract the divisor
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        take    = (shifted >= {1'b0, divisor_reg});
    end

    // Load on start, otherwise advance one bit while steps remain
    always_comb
    begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        done_next    = 1'b0;
        if (start)
        begin
            quo_next     = dividend;
            rem_next     = '0;
            divisor_next = divisor;
            step_next    = STEP_W'(DIVIDEND_W);
        end
        else if (step_reg != '0)
        begin
            // Remainder stays below the divisor, so its top bit is always clear
            rem_next  = take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], take};
            step_next = step_reg - STEP_W'(1);
            done_next = (step_reg == STEP_W'(1));
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/windowed_running_average_core.sv =====
// Windowed running average: ring store of the last DEPTH samples with running sum and mean.
// Depends on wra_pkg and wra_div.
//
// Usage:
//   req channel (req_valid/req_ready, req) carries one op: push a sample or clear.
//   rsp channel (rsp_valid/rsp_ready, rsp) returns one transaction per request:
//   fill count, write pointer, window sum and the mean in Q.8 (zero when empty).
//   req_ready is high only while the sequencer is idle; one request is worked at
//   a time. A push passes through the update, divide and emit states to
//   rsp_valid, where the bit-serial divider forms the mean one quotient bit per
//   cycle; a clear goes from update straight to emit.
//   req_ready returns with rsp_valid.
//   The store is read at the accept edge and written in the following cycle, on
//   its single port. The response sits in an output register: a new request is
//   taken while a finished one waits, and only the final hand-off waits for
//   rsp_ready, so a stalled receiver holds the block once its next result is done.
//   Reset clears pointer, count, sum, the sequencer and rsp_valid; store contents
//   are not cleared and need not be, since an entry is only read back as the
//   oldest once the window is full.
`default_nettype none

module windowed_running_average_core #(
    parameter int unsigned DEPTH       = 64,
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire wra_pkg::wra_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output wra_pkg::wra_rsp_t      rsp
);

    import wra_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
    localparam int unsigned QUO_W = SUM_W + FRAC_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } wra_state_t;

    wra_state_t state_reg, state_next;

    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;

    logic                   op_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic [SAMPLE_BITS-1:0] store_mem [DEPTH];

    wra_rsp_t rsp_reg;
    logic     rsp_valid_reg, rsp_valid_next;

    logic                    req_fire;
    logic                    store_we;
    logic                    rsp_load;
    logic                    full;
    logic [PTR_W-1:0]        ptr_adv;
    logic [SUM_W-1:0]        sum_sub;
    logic [SUM_W-1:0]        sum_push;
    logic [SAMPLE_W_MAX-1:0] sample_ext;
    logic                    div_start;
    logic                    div_done;
    logic [QUO_W-1:0]        div_quotient;
    logic [63:0]             cnt_ext;
    logic [63:0]             ptr_ext;
    logic [63:0]             sum_ext;
    logic [63:0]             quo_ext;
    wra_rsp_t                rsp_build;

    assign req_fire   = req_valid && req_ready;
    assign req_ready  = (state_reg == ST_IDLE);
    assign sample_ext = SAMPLE_W_MAX'(req.sample);

    // Window arithmetic for a push: advance pointer, add new and drop oldest when full
    always_comb
    begin
        full     = (count_reg == CNT_W'(DEPTH));
        ptr_adv  = (ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
        sum_sub  = full ? SUM_W'(rd_data_reg) : '0;
        sum_push = sum_reg + SUM_W'(sample_reg) - sum_sub;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        store_we   = 1'b0;
        div_start  = 1'b0;
        rsp_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (op_reg == OP_CLEAR)
                begin
                    ptr_next   = '0;
                    count_next = '0;
                    sum_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    store_we   = 1'b1;
                    ptr_next   = ptr_adv;
                    count_next = full ? count_reg : count_reg + CNT_W'(1);
                    sum_next   = sum_push;
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the response until taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Fit the window state into the response fields
    always_comb
    begin
        cnt_ext = 64'(count_reg);
        ptr_ext = 64'(ptr_reg);
        sum_ext = 64'(sum_reg);
        quo_ext = 64'(div_quotient);
        rsp_build.fill_count    = cnt_ext[FILL_W-1:0];
        rsp_build.write_pointer = ptr_ext[PTR_FIELD_W-1:0];
        rsp_build.window_sum    = sum_ext[SUM_FIELD_W-1:0];
        rsp_build.mean_q8       = (count_reg == '0) ? '0 : quo_ext[MEAN_W-1:0];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Capture the request and the response payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg     <= req.op;
            sample_reg <= sample_ext[SAMPLE_BITS-1:0];
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_build;
        end
    end

    // Sample store: write the new sample, read the entry at the pointer
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[ptr_reg] <= sample_reg;
        end
        rd_data_reg <= store_mem[ptr_reg];
    end

    wra_div #(
        .DIVIDEND_W (QUO_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_next, FRAC_W'(0)}),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/wra_checker.sv =====
// Port-level checks for the windowed running average core, and their bind.
// Depends on wra_pkg; attaches to windowed_running_average_core.
`default_nettype none

module wra_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire wra_pkg::wra_rsp_t rsp
);

    import wra_pkg::*;

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed or dropped while stalled");

    // One request at a time: accepting a request drops ready
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    // An empty window reports zero pointer, sum and mean
    a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.fill_count == '0) |->
            (rsp.write_pointer == '0) && (rsp.window_sum == '0) && (rsp.mean_q8 == '0))
        else $error("empty window reports nonzero state");

    // A single-sample window has mean equal to its sum
    a_single_mean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.fill_count == FILL_W'(1)) |->
            rsp.mean_q8 == {rsp.window_sum[MEAN_W-FRAC_W-1:0], FRAC_W'(0)})
        else $error("mean of a single sample differs from the sample");

endmodule

bind windowed_running_average_core wra_checker u_wra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
